// File: rtl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants of the slot free-list allocator.
// ----------------------------------------------------------------------------
package sfl_pkg;

    localparam int KEY_IN_W  = 32;
    localparam int IDX_OUT_W = 3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [KEY_IN_W-1:0] owner_key;
    } t_in_item;

    typedef struct packed {
        logic                 success;
        logic [IDX_OUT_W-1:0] slot_index;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic alloc_rd;
        logic alloc_wr;
        logic walk_start;
        logic walk_next;
        logic unlink;
        logic push;
        logic fail;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic req_free;
        logic free_ok;
        logic used_ok;
        logic match;
        logic next_ok;
        logic out_space;
    } t_dp_sts;

endpackage

// File: rtl/sfl_ctrl.sv
// ----------------------------------------------------------------------------
// sfl_ctrl
// Sequencer: allocate, used-list walk, unlink, push and result delivery.
// ----------------------------------------------------------------------------
module sfl_ctrl
    import sfl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_A_RD    = 7'b0000010,
        ST_A_WR    = 7'b0000100,
        ST_F_START = 7'b0001000,
        ST_F_CMP   = 7'b0010000,
        ST_F_PUSH  = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.req_free ? ST_F_START : ST_A_RD;
                end
            end
            ST_A_RD: begin
                if (i_sts.free_ok) begin
                    o_cmd.alloc_rd = 1'b1;
                    n_state        = ST_A_WR;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_A_WR: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = ST_DONE;
            end
            ST_F_START: begin
                if (i_sts.used_ok) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = ST_F_CMP;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_F_CMP: begin
                if (i_sts.match) begin
                    o_cmd.unlink = 1'b1;
                    n_state      = ST_F_PUSH;
                end else if (i_sts.next_ok) begin
                    o_cmd.walk_next = 1'b1;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_F_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_space) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sfl_dp.sv
// ----------------------------------------------------------------------------
// sfl_dp
// List heads, link table, tag store, walk pointers and output register.
// ----------------------------------------------------------------------------
module sfl_dp
    import sfl_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int KEY_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int AW    = $clog2(SLOT_COUNT);
    localparam int IDX_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] NONE = IDX_W'(SLOT_COUNT);

    logic [IDX_W-1:0]     r_free_head, n_free_head;
    logic [IDX_W-1:0]     r_used_head, n_used_head;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     r_prev;
    logic [KEY_WIDTH-1:0] r_key;
    logic [IDX_W-1:0]     r_link_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_link_vld;
    logic [IDX_W-1:0]     r_link_rd;
    logic [KEY_WIDTH-1:0] r_tag_mem [SLOT_COUNT];
    logic [KEY_WIDTH-1:0] r_tag_rd;
    logic                 r_res_ok;
    logic [IDX_W-1:0]     r_res_idx;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     wr_data;
    logic                 prev_ok;

    logic [KEY_IN_W+KEY_WIDTH-1:0] key_wide;
    logic [IDX_W+IDX_OUT_W-1:0]    idx_wide;

    assign key_wide = {{KEY_WIDTH{1'b0}}, i_in_data.owner_key};
    assign idx_wide = {{IDX_OUT_W{1'b0}}, r_res_idx};
    assign prev_ok  = (r_prev < NONE);

    assign o_sts.req_free  = (i_in_data.func == FUNC_FREE);
    assign o_sts.free_ok   = (r_free_head < NONE);
    assign o_sts.used_ok   = (r_used_head < NONE);
    assign o_sts.match     = (r_tag_rd == r_key);
    assign o_sts.next_ok   = (r_link_rd < NONE);
    assign o_sts.out_space = !r_out_valid || i_out_ready;

    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = r_cur;
        wr_en       = 1'b0;
        wr_addr     = r_cur;
        wr_data     = r_used_head;
        n_free_head = r_free_head;
        n_used_head = r_used_head;
        if (i_cmd.alloc_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_free_head;
        end
        if (i_cmd.walk_start) begin
            rd_en   = 1'b1;
            rd_addr = r_used_head;
        end
        if (i_cmd.walk_next) begin
            rd_en   = 1'b1;
            rd_addr = r_link_rd;
        end
        if (i_cmd.alloc_wr) begin
            wr_en       = 1'b1;
            wr_addr     = r_cur;
            wr_data     = r_used_head;
            n_used_head = r_cur;
            n_free_head = r_link_rd;
        end
        if (i_cmd.unlink) begin
            if (prev_ok) begin
                wr_en   = 1'b1;
                wr_addr = r_prev;
                wr_data = r_link_rd;
            end else begin
                n_used_head = r_link_rd;
            end
        end
        if (i_cmd.push) begin
            wr_en       = 1'b1;
            wr_addr     = r_cur;
            wr_data     = r_free_head;
            n_free_head = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_used_head <= NONE;
            r_link_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            if (wr_en) begin
                r_link_vld[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // link table and tag store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_link_rd <= r_link_vld[rd_addr[AW-1:0]] ? r_link_mem[rd_addr[AW-1:0]]
                                                     : rd_addr + IDX_W'(1);
        end
        if (i_cmd.alloc_rd) begin
            r_tag_mem[r_free_head[AW-1:0]] <= r_key;
        end
        if (rd_en) begin
            r_tag_rd <= r_tag_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= key_wide[KEY_WIDTH-1:0];
        end
        if (i_cmd.alloc_rd) begin
            r_cur <= r_free_head;
        end
        if (i_cmd.walk_start) begin
            r_cur  <= r_used_head;
            r_prev <= NONE;
        end
        if (i_cmd.walk_next) begin
            r_cur  <= r_link_rd;
            r_prev <= r_cur;
        end
        if (i_cmd.alloc_wr || i_cmd.push) begin
            r_res_ok  <= 1'b1;
            r_res_idx <= r_cur;
        end
        if (i_cmd.fail) begin
            r_res_ok  <= 1'b0;
            r_res_idx <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_data.success    <= r_res_ok;
            r_out_data.slot_index <= idx_wide[IDX_OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/slot_free_list_allocator.sv
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Slot pool kept as a free list and a used list in one link table.
// ----------------------------------------------------------------------------
// One request is handled at a time. Allocate reads the free-list head, then
// links that slot onto the used list; an empty pool gives a failed result. Free
// walks the used list until the key matches, unlinks that node and pushes it
// onto the free list, or fails when the key is absent; the walk visits
// one node per cycle through the registered read port of the link table and
// tag store. A new request is taken while the previous result waits in the
// output register. Reset needs no clearing pass: the link table reads its
// initial chain through per-entry valid bits.
module slot_free_list_allocator
    import sfl_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int KEY_WIDTH  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sfl_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending one");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an input transfer");

    a_one_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.alloc_wr, cmd.push, cmd.fail}))
        else $error("two result sources in one cycle");

endmodule
